FILE: rtl/bdq_pkg.sv
// shared constants, opcodes and controller/datapath interface types for the deque unit
`default_nettype none
package bdq_pkg;

    // storage geometry; DEPTH is a power of two so slot arithmetic wraps
    localparam int DEPTH  = 16;
    localparam int WIDTH  = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // beat field widths
    localparam int FUNC_W   = 3;
    localparam int POS_W    = 5;
    localparam int STAT_W   = 2;
    localparam int CMP_W    = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;
    localparam int S_DATA_W = ((WIDTH + POS_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((WIDTH + STAT_W + CNT_W + 1 + 7) / 8) * 8;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd1;
    localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_INSERT     = 3'd4;
    localparam logic [FUNC_W-1:0] FN_READ       = 3'd5;
    localparam logic [FUNC_W-1:0] FN_PEEK_FRONT = 3'd6;
    localparam logic [FUNC_W-1:0] FN_PEEK_BACK  = 3'd7;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd3;

    typedef struct packed {
        logic latch;      // capture the input beat
        logic err;        // post an error result, no state change
        logic push;       // push front or back and post result
        logic rd_issue;   // read one store entry into the read register
        logic read_done;  // post read data, retire pop
        logic ins_start;  // load shift index with the count
        logic shift_wr;   // move read entry one slot toward the back
        logic ins_fin;    // write inserted value and post result
    } bdq_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              err;
        logic              pos_at_end;
        logic              shift_last;
        logic              out_free;
    } bdq_stat_t;

endpackage
`default_nettype wire

FILE: rtl/bdq_ctrl.sv
// controller state machine that sequences each deque operation
`default_nettype none
module bdq_ctrl (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_tvalid,
    output logic               s_tready,
    input  bdq_pkg::bdq_stat_t stat,
    output bdq_pkg::bdq_cmd_t  cmd
);
    import bdq_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_RDWAIT = 3'd2;
    localparam logic [2:0] S_SHRD   = 3'd3;
    localparam logic [2:0] S_SHWR   = 3'd4;
    localparam logic [2:0] S_INSFIN = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == S_IDLE) && stat.out_free;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (stat.err) begin
                    cmd.err    = 1'b1;
                    state_next = S_IDLE;
                end else if (stat.func == FN_PUSH_BACK || stat.func == FN_PUSH_FRONT) begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end else if (stat.func == FN_INSERT) begin
                    cmd.ins_start = 1'b1;
                    state_next    = stat.pos_at_end ? S_INSFIN : S_SHRD;
                end else begin
                    cmd.rd_issue = 1'b1;
                    state_next   = S_RDWAIT;
                end
            end
            S_RDWAIT: begin
                cmd.read_done = 1'b1;
                state_next    = S_IDLE;
            end
            S_SHRD: begin
                cmd.rd_issue = 1'b1;
                state_next   = S_SHWR;
            end
            S_SHWR: begin
                cmd.shift_wr = 1'b1;
                state_next   = stat.shift_last ? S_INSFIN : S_SHRD;
            end
            S_INSFIN: begin
                cmd.ins_fin = 1'b1;
                state_next  = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/bdq_datapath.sv
// element store, pointers, operation registers and result register of the deque unit
`default_nettype none
module bdq_datapath (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire  [bdq_pkg::S_DATA_W-1:0]   s_tdata,
    input  wire  [bdq_pkg::FUNC_W-1:0]     s_tuser,
    output logic                           m_tvalid,
    input  wire                            m_tready,
    output logic [bdq_pkg::M_DATA_W-1:0]   m_tdata,
    input  bdq_pkg::bdq_cmd_t              cmd,
    output bdq_pkg::bdq_stat_t             stat
);
    import bdq_pkg::*;

    logic [WIDTH-1:0]  mem [DEPTH];
    logic [WIDTH-1:0]  rd_data_reg;

    logic [FUNC_W-1:0] op_func_reg;
    logic [WIDTH-1:0]  op_value_reg;
    logic [POS_W-1:0]  op_pos_reg;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [ADDR_W-1:0] front_reg;
    logic [ADDR_W-1:0] front_next;
    logic [CNT_W-1:0]  idx_reg;

    logic              m_valid_reg;
    logic [WIDTH-1:0]  res_data_reg;
    logic [STAT_W-1:0] res_status_reg;
    logic [CNT_W-1:0]  res_count_reg;
    logic              res_empty_reg;

    logic [STAT_W-1:0] op_status;
    logic              full;
    logic              empty;
    logic [ADDR_W-1:0] back_slot;
    logic [ADDR_W-1:0] end_slot;
    logic [ADDR_W-1:0] pos_slot;
    logic [ADDR_W-1:0] idx_slot;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [WIDTH-1:0]  wr_data;
    logic              wr_en;
    logic              load_res;
    logic              is_pop;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    // logical index to physical slot, wraps at the store depth
    assign end_slot  = front_reg + count_reg[ADDR_W-1:0];
    assign back_slot = end_slot - ADDR_W'(1);
    assign pos_slot  = front_reg + op_pos_reg[ADDR_W-1:0];
    assign idx_slot  = front_reg + idx_reg[ADDR_W-1:0];

    always_comb begin
        op_status = STAT_OK;
        case (op_func_reg) inside
            FN_PUSH_BACK, FN_PUSH_FRONT: begin
                if (full) op_status = STAT_FULL;
            end
            FN_POP_BACK, FN_POP_FRONT, FN_PEEK_FRONT, FN_PEEK_BACK: begin
                if (empty) op_status = STAT_EMPTY;
            end
            FN_INSERT: begin
                if (CMP_W'(op_pos_reg) > CMP_W'(count_reg)) op_status = STAT_RANGE;
                else if (full) op_status = STAT_FULL;
            end
            FN_READ: begin
                if (CMP_W'(op_pos_reg) >= CMP_W'(count_reg)) op_status = STAT_RANGE;
            end
            default: begin
                op_status = STAT_OK;
            end
        endcase
    end

    always_comb begin
        case (op_func_reg) inside
            FN_POP_BACK, FN_PEEK_BACK:   rd_addr = back_slot;
            FN_POP_FRONT, FN_PEEK_FRONT: rd_addr = front_reg;
            FN_INSERT:                   rd_addr = idx_slot - ADDR_W'(1);
            default:                     rd_addr = pos_slot;
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = pos_slot;
        wr_data = op_value_reg;
        if (cmd.push) begin
            wr_en   = 1'b1;
            wr_addr = (op_func_reg == FN_PUSH_FRONT) ? front_reg - ADDR_W'(1) : end_slot;
        end else if (cmd.shift_wr) begin
            wr_en   = 1'b1;
            wr_addr = idx_slot;
            wr_data = rd_data_reg;
        end else if (cmd.ins_fin) begin
            wr_en   = 1'b1;
        end
    end

    assign is_pop = (op_func_reg == FN_POP_BACK) || (op_func_reg == FN_POP_FRONT);

    always_comb begin
        count_next = count_reg;
        front_next = front_reg;
        if (cmd.push || cmd.ins_fin) begin
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.push && op_func_reg == FN_PUSH_FRONT) begin
            front_next = front_reg - ADDR_W'(1);
        end
        if (cmd.read_done && is_pop) begin
            count_next = count_reg - CNT_W'(1);
        end
        if (cmd.read_done && op_func_reg == FN_POP_FRONT) begin
            front_next = front_reg + ADDR_W'(1);
        end
    end

    assign load_res = cmd.err || cmd.push || cmd.read_done || cmd.ins_fin;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_issue) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            op_func_reg  <= s_tuser;
            op_value_reg <= s_tdata[WIDTH-1:0];
            op_pos_reg   <= s_tdata[WIDTH +: POS_W];
        end
        if (cmd.ins_start) begin
            idx_reg <= count_reg;
        end else if (cmd.shift_wr) begin
            idx_reg <= idx_reg - CNT_W'(1);
        end
        if (load_res) begin
            res_data_reg   <= cmd.read_done ? rd_data_reg : '0;
            res_status_reg <= cmd.err ? op_status : STAT_OK;
            res_count_reg  <= count_next;
            res_empty_reg  <= (count_next == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            front_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            front_reg <= front_next;
            if (load_res) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.func       = op_func_reg;
    assign stat.err        = (op_status != STAT_OK);
    assign stat.pos_at_end = (CNT_W'(op_pos_reg) == count_reg);
    assign stat.shift_last = ((idx_reg - CNT_W'(1)) == CNT_W'(op_pos_reg));
    assign stat.out_free   = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'({res_empty_reg, res_count_reg, res_status_reg, res_data_reg});

endmodule
`default_nettype wire

FILE: rtl/bounded_deque_with_index_insert_unit.sv
// top level of the bounded deque with indexed read and indexed insert
`default_nettype none
// Bounded double-ended queue of 16 entries of 32 bits. Each input beat carries one
// operation in s_tuser (push back/front, pop back/front, insert at, read at, peek
// front/back) and gives exactly one result beat with data, status, new count and an
// empty flag. Items are taken one at a time: push and error results are posted from
// the execute state; pop, peek and read first load the entry into a read register
// (the store read is registered); an insert at p shifts the entries from p one slot
// back, one per read/write pair of the single-ported store, then writes the value.
// A new beat is accepted once the previous result has been taken or is taken in the
// same cycle. Store contents are undefined after reset; only written slots are read.
module bounded_deque_with_index_insert_unit (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    // [31:0] value, [36:32] position
    input  wire  [bdq_pkg::S_DATA_W-1:0] s_tdata,
    // [2:0] func
    input  wire  [bdq_pkg::FUNC_W-1:0]   s_tuser,
    output logic                         m_tvalid,
    input  wire                          m_tready,
    // [31:0] data, [33:32] status, [38:34] count, [39] is_empty
    output logic [bdq_pkg::M_DATA_W-1:0] m_tdata
);
    import bdq_pkg::*;

    bdq_cmd_t  cmd;
    bdq_stat_t stat;

    bdq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bdq_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

`ifndef SYNTHESIS
    // a result is only posted into an empty output register
    a_res_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.err || cmd.push || cmd.read_done || cmd.ins_fin) |-> !m_tvalid)
        else $error("result posted over an unconsumed beat");

    // at most one result-producing command per cycle
    a_one_res: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.err, cmd.push, cmd.read_done, cmd.ins_fin}))
        else $error("more than one result command");

    // reported count never exceeds the store depth
    a_cnt_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[WIDTH+STAT_W +: CNT_W] <= CNT_W'(DEPTH)))
        else $error("count above depth");

    // empty flag agrees with the reported count
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[WIDTH+STAT_W+CNT_W] == (m_tdata[WIDTH+STAT_W +: CNT_W] == '0)))
        else $error("empty flag mismatch");
`endif

endmodule
`default_nettype wire

FILE: sim/bounded_deque_with_index_insert_unit_test.sv
// testbench for the bounded deque unit: random and directed beats checked against a predictor
`timescale 1ns / 100ps

module bounded_deque_with_index_insert_unit_test;
    import bdq_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 1200;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic [WIDTH-1:0]  data;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  count;
        logic              is_empty;
    } deque_result_t;

    class deque_scoreboard;
        logic [WIDTH-1:0]  store [DEPTH];
        logic [ADDR_W-1:0] front;
        int                held;
        deque_result_t     expected_results [$];
        int                mismatches;

        function new();
            front = '0;
            held = 0;
            mismatches = 0;
        endfunction

        function logic [ADDR_W-1:0] slot(int logical);
            return ADDR_W'((int'(front) + logical) % DEPTH);
        endfunction

        function int occupancy();
            return held;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // apply one accepted request and queue the result it should give
        function void note_request(logic [FUNC_W-1:0] func, logic [WIDTH-1:0] value,
                                   logic [POS_W-1:0] pos);
            deque_result_t r;
            r.data = '0;
            r.status = STAT_OK;
            case (func)
                FN_PUSH_BACK, FN_PUSH_FRONT: begin
                    if (held >= DEPTH) begin
                        r.status = STAT_FULL;
                    end else if (func == FN_PUSH_BACK) begin
                        store[slot(held)] = value;
                        held++;
                    end else begin
                        front = front - 1'b1;
                        store[front] = value;
                        held++;
                    end
                end
                FN_POP_BACK, FN_POP_FRONT: begin
                    if (held == 0) begin
                        r.status = STAT_EMPTY;
                    end else if (func == FN_POP_BACK) begin
                        r.data = store[slot(held - 1)];
                        held--;
                    end else begin
                        r.data = store[front];
                        front = front + 1'b1;
                        held--;
                    end
                end
                FN_INSERT: begin
                    if (int'(pos) > held) begin
                        r.status = STAT_RANGE;
                    end else if (held >= DEPTH) begin
                        r.status = STAT_FULL;
                    end else begin
                        for (int i = held; i > int'(pos); i--)
                            store[slot(i)] = store[slot(i - 1)];
                        store[slot(int'(pos))] = value;
                        held++;
                    end
                end
                FN_READ: begin
                    if (int'(pos) >= held)
                        r.status = STAT_RANGE;
                    else
                        r.data = store[slot(int'(pos))];
                end
                FN_PEEK_FRONT: begin
                    if (held == 0)
                        r.status = STAT_EMPTY;
                    else
                        r.data = store[front];
                end
                default: begin
                    if (held == 0)
                        r.status = STAT_EMPTY;
                    else
                        r.data = store[slot(held - 1)];
                end
            endcase
            r.count = CNT_W'(held);
            r.is_empty = (held == 0);
            expected_results = {expected_results, r};
        endfunction

        function void check_result(logic [M_DATA_W-1:0] beat);
            deque_result_t e;
            deque_result_t a;
            a.data = beat[WIDTH-1:0];
            a.status = beat[WIDTH+STAT_W-1:WIDTH];
            a.count = beat[WIDTH+STAT_W+CNT_W-1:WIDTH+STAT_W];
            a.is_empty = beat[WIDTH+STAT_W+CNT_W];
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: data %h status %0d count %0d empty %0d",
                             a.data, a.status, a.count, a.is_empty);
                return;
            end
            e = expected_results[0];
            expected_results.delete(0);
            if (a.data !== e.data || a.status !== e.status || a.count !== e.count ||
                a.is_empty !== e.is_empty) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result mismatch: expected data %h status %0d count %0d empty %0d",
                             e.data, e.status, e.count, e.is_empty);
                    $display("                 got      data %h status %0d count %0d empty %0d",
                             a.data, a.status, a.count, a.is_empty);
                end
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [FUNC_W-1:0]   s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    deque_scoreboard sb;
    int  cycles;
    bit  calm;
    bit  filling;

    bounded_deque_with_index_insert_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // mostly short gaps, now and then a long one
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_item(logic [FUNC_W-1:0] func, logic [WIDTH-1:0] value,
                             logic [POS_W-1:0] pos);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= {{(S_DATA_W - WIDTH - POS_W){1'b0}}, pos, value};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(func, value, pos);
        @(negedge aclk);
    endtask

    function logic [WIDTH-1:0] pick_value();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom;
    endfunction

    // fill phases grow the deque toward full, drain phases shrink it
    task automatic pick_random(output logic [FUNC_W-1:0] func, output logic [POS_W-1:0] pos);
        int cnt;
        int r;
        cnt = sb.occupancy();
        r = $urandom_range(0, 99);
        pos = POS_W'($urandom_range(0, 31));
        if (r < 10) begin
            func = FUNC_W'($urandom_range(0, 7));
            return;
        end
        r = $urandom_range(0, 99);
        if (filling) begin
            if (r < 30)
                func = FN_PUSH_BACK;
            else if (r < 50)
                func = FN_PUSH_FRONT;
            else if (r < 80)
                func = FN_INSERT;
            else if (r < 88)
                func = FN_READ;
            else if (r < 92)
                func = FN_PEEK_FRONT;
            else if (r < 95)
                func = FN_PEEK_BACK;
            else
                func = (r[0]) ? FN_POP_BACK : FN_POP_FRONT;
        end else begin
            if (r < 30)
                func = FN_POP_BACK;
            else if (r < 60)
                func = FN_POP_FRONT;
            else if (r < 75)
                func = FN_READ;
            else if (r < 80)
                func = FN_PEEK_FRONT;
            else if (r < 85)
                func = FN_PEEK_BACK;
            else if (r < 93)
                func = FN_INSERT;
            else
                func = FN_PUSH_BACK;
        end
        if (func == FN_INSERT && $urandom_range(0, 9) != 0)
            pos = POS_W'($urandom_range(0, cnt));
        if (func == FN_READ && cnt > 0 && $urandom_range(0, 7) != 0)
            pos = POS_W'($urandom_range(0, cnt - 1));
    endtask

    // result side: random backpressure with long and short stalls
    initial begin
        int stall;
        m_tready = 1'b0;
        stall = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!calm && stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        logic [FUNC_W-1:0] func;
        logic [POS_W-1:0]  pos;
        sb = new();
        cycles = 0;
        calm = 1'b0;
        filling = 1'b1;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = FN_PUSH_BACK;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // corner cases on an empty deque, then on a short deque
        send_item(FN_POP_BACK, pick_value(), 5'd0);
        send_item(FN_POP_FRONT, pick_value(), 5'd0);
        send_item(FN_PEEK_FRONT, pick_value(), 5'd0);
        send_item(FN_PEEK_BACK, pick_value(), 5'd0);
        send_item(FN_READ, pick_value(), 5'd0);
        send_item(FN_INSERT, pick_value(), 5'd1);
        send_item(FN_INSERT, 32'h1234_5678, 5'd0);
        send_item(FN_PUSH_BACK, '1, 5'd31);
        send_item(FN_PUSH_FRONT, '0, 5'd0);
        send_item(FN_INSERT, pick_value(), 5'd3);
        send_item(FN_INSERT, pick_value(), 5'd2);
        send_item(FN_READ, pick_value(), 5'd31);
        send_item(FN_READ, pick_value(), 5'd4);
        send_item(FN_PEEK_FRONT, pick_value(), 5'd0);
        send_item(FN_PEEK_BACK, pick_value(), 5'd0);
        // fill up with inserts at random places so the shift walk gets long
        while (sb.occupancy() < DEPTH)
            send_item(FN_INSERT, pick_value(), POS_W'($urandom_range(0, sb.occupancy())));
        send_item(FN_PUSH_BACK, pick_value(), 5'd0);
        send_item(FN_PUSH_FRONT, pick_value(), 5'd0);
        send_item(FN_INSERT, pick_value(), 5'd16);
        send_item(FN_INSERT, pick_value(), 5'd17);
        send_item(FN_INSERT, pick_value(), 5'd0);
        send_item(FN_READ, pick_value(), 5'd15);
        send_item(FN_POP_BACK, pick_value(), 5'd0);
        send_item(FN_POP_FRONT, pick_value(), 5'd0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= 200 && n < 350) || (n >= 900 && n < 1000);
            if (n == 600) begin
                // hold off until the unit has answered everything
                s_tvalid <= 1'b0;
                do @(negedge aclk); while (sb.pending() != 0);
            end
            pick_random(func, pos);
            send_item(func, pick_value(), pos);
            if (sb.occupancy() == DEPTH && $urandom_range(0, 3) == 0)
                filling = 1'b0;
            else if (sb.occupancy() == 0)
                filling = 1'b1;
            else if ($urandom_range(0, 39) == 0)
                filling = !filling;
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: sim.f
rtl/bdq_pkg.sv
rtl/bdq_ctrl.sv
rtl/bdq_datapath.sv
rtl/bounded_deque_with_index_insert_unit.sv
sim/bounded_deque_with_index_insert_unit_test.sv
